@@ rtl/core/alarm_sequence_pulser_top_defines.svh @@
// ----------------------------------------------------------------------------
// alarm sequence pulser assertion macros
// shared concurrent check forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef ALARM_SEQUENCE_PULSER_TOP_DEFINES_SVH
`define ALARM_SEQUENCE_PULSER_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define ASP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asp: same-cycle check failed");

// consequent in the cycle after the antecedent
`define ASP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asp: next-cycle check failed");

`endif

@@ rtl/core/asp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asp_pkg
// types, constants and register codes of the alarm sequence pulser
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int NUM_SEQUENCES = 4;
  localparam int TIME_WIDTH    = 16;
  localparam int CNT_W         = TIME_WIDTH + 2;
  localparam int SEQ_W         = (NUM_SEQUENCES > 2) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int SEL_W         = 2;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int FUNC_W        = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_1        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME_1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_2        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME_2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_3        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME_3       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELAY_ACTIVE_LOW = 3'd6;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ABOVE   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_BELOW   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_OUTSIDE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLAG    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic signed [15:0]  reading;
    logic signed [15:0]  threshold;
    logic signed [15:0]  range_min;
    logic signed [15:0]  range_max;
    logic [SEL_W-1:0]    sequence_select;
  } in_item_t;

  typedef struct packed {
    logic             relay_on;
    logic             pin_level;
    logic             alarm_idle;
    logic [SEL_W-1:0] playing_sequence;
  } out_item_t;

  typedef struct packed {
    logic [NUM_SEQUENCES-1:0][TIME_WIDTH-1:0] on_time;
    logic [NUM_SEQUENCES-1:0][TIME_WIDTH-1:0] off_time;
    logic                                     relay_active_low;
  } cfg_regs_t;

  // decoded transaction kind and condition outcome
  typedef struct packed {
    logic is_tick;
    logic apply;
    logic hit;
  } cond_res_t;

  function automatic logic [TIME_WIDTH-1:0] to_time(input logic [CFG_W-1:0] d);
    logic [CFG_W+TIME_WIDTH-1:0] ext;
    ext = {{TIME_WIDTH{1'b0}}, d};
    return ext[TIME_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/asp_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asp_cfg_regs
// sequence timing and relay polarity registers behind the write port
// ----------------------------------------------------------------------------
module asp_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [asp_pkg::CFG_W-1:0]      cfg_wdata,
  output asp_pkg::cfg_regs_t                  cfg
);

  asp_pkg::cfg_regs_t cfg_r, cfg_nxt;
  logic                        time_we;
  logic                        time_off;
  logic [asp_pkg::SEL_W-1:0]   time_seq;
  logic                        pol_we;

  always_comb begin
    time_we  = 1'b0;
    time_off = 1'b0;
    time_seq = '0;
    pol_we   = 1'b0;
    case (cfg_index)
      asp_pkg::REG_ON_TIME_1: begin
        time_we = 1'b1; time_seq = 2'd1;
      end
      asp_pkg::REG_OFF_TIME_1: begin
        time_we = 1'b1; time_seq = 2'd1; time_off = 1'b1;
      end
      asp_pkg::REG_ON_TIME_2: begin
        time_we = 1'b1; time_seq = 2'd2;
      end
      asp_pkg::REG_OFF_TIME_2: begin
        time_we = 1'b1; time_seq = 2'd2; time_off = 1'b1;
      end
      asp_pkg::REG_ON_TIME_3: begin
        time_we = 1'b1; time_seq = 2'd3;
      end
      asp_pkg::REG_OFF_TIME_3: begin
        time_we = 1'b1; time_seq = 2'd3; time_off = 1'b1;
      end
      asp_pkg::REG_RELAY_ACTIVE_LOW: begin
        pol_we = 1'b1;
      end
      default: begin
        time_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      // sequence 0 is fixed, so its slot is never written
      for (int k = 1; k < asp_pkg::NUM_SEQUENCES; k++) begin
        if (time_we && time_seq == asp_pkg::SEL_W'(k)) begin
          if (time_off) begin
            cfg_nxt.off_time[k] = asp_pkg::to_time(cfg_wdata);
          end else begin
            cfg_nxt.on_time[k] = asp_pkg::to_time(cfg_wdata);
          end
        end
      end
      if (pol_we) begin
        cfg_nxt.relay_active_low = cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/core/asp_cond_eval.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asp_cond_eval
// decodes the transaction kind and evaluates the alarm condition
// ----------------------------------------------------------------------------
module asp_cond_eval (
  input  wire asp_pkg::in_item_t  item,
  output asp_pkg::cond_res_t      res
);

  logic sel_ok;
  logic above, below, outside, flag;

  assign sel_ok  = {1'b0, item.sequence_select} < (asp_pkg::SEL_W + 1)'(asp_pkg::NUM_SEQUENCES);
  assign above   = $signed(item.reading) > $signed(item.threshold);
  assign below   = $signed(item.reading) < $signed(item.threshold);
  assign outside = ($signed(item.reading) < $signed(item.range_min)) ||
                   ($signed(item.reading) > $signed(item.range_max));
  assign flag    = item.threshold != 16'sd0;

  always_comb begin
    res = '0;
    case (item.func)
      asp_pkg::FUNC_TICK: begin
        res.is_tick = 1'b1;
      end
      asp_pkg::FUNC_ABOVE: begin
        res.apply = sel_ok; res.hit = above;
      end
      asp_pkg::FUNC_BELOW: begin
        res.apply = sel_ok; res.hit = below;
      end
      asp_pkg::FUNC_OUTSIDE: begin
        res.apply = sel_ok; res.hit = outside;
      end
      asp_pkg::FUNC_FLAG: begin
        res.apply = sel_ok; res.hit = flag;
      end
      // unused codes leave the state alone
      default: begin
        res = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/asp_seq_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asp_seq_core
// sequence state, elapsed tick counter and relay level
// ----------------------------------------------------------------------------
module asp_seq_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire asp_pkg::cond_res_t         cond,
  input  wire logic [asp_pkg::SEL_W-1:0]  sel,
  input  wire asp_pkg::cfg_regs_t         cfg,
  output asp_pkg::out_item_t              result
);

  logic                               idle_r, idle_nxt;
  logic [asp_pkg::SEQ_W-1:0]          seq_r, seq_nxt;
  logic [asp_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                               relay_r, relay_nxt;

  logic [asp_pkg::TIME_WIDTH-1:0]     on_t, off_t;
  logic [asp_pkg::TIME_WIDTH:0]       period;
  logic [asp_pkg::CNT_W-1:0]          cnt_inc;
  logic [asp_pkg::SEQ_W-1:0]          sel_idx;

  assign on_t    = cfg.on_time[seq_r];
  assign off_t   = cfg.off_time[seq_r];
  assign period  = {1'b0, on_t} + {1'b0, off_t};
  assign cnt_inc = (cnt_r == asp_pkg::COUNT_MAX) ? cnt_r : cnt_r + asp_pkg::CNT_W'(1);
  assign sel_idx = sel[asp_pkg::SEQ_W-1:0];

  always_comb begin
    idle_nxt  = idle_r;
    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    relay_nxt = relay_r;
    if (cond.is_tick) begin
      if (idle_r) begin
        relay_nxt = 1'b0;
        cnt_nxt   = '0;
      end else if (seq_r == '0 || off_t == '0) begin
        relay_nxt = 1'b1;
        cnt_nxt   = '0;
      end else if (cnt_r < asp_pkg::CNT_W'(on_t)) begin
        relay_nxt = 1'b1;
        cnt_nxt   = cnt_inc;
      end else if (cnt_r < asp_pkg::CNT_W'(period)) begin
        relay_nxt = 1'b0;
        cnt_nxt   = cnt_inc;
      end else begin
        // restart tick, relay holds its level
        cnt_nxt = '0;
      end
    end else if (cond.apply) begin
      if (cond.hit) begin
        seq_nxt  = sel_idx;
        idle_nxt = 1'b0;
      end else if (!idle_r && seq_r == sel_idx) begin
        idle_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r  <= 1'b1;
      seq_r   <= '0;
      cnt_r   <= '0;
      relay_r <= 1'b0;
    end else if (step) begin
      idle_r  <= idle_nxt;
      seq_r   <= seq_nxt;
      cnt_r   <= cnt_nxt;
      relay_r <= relay_nxt;
    end
  end

  always_comb begin
    result.relay_on         = relay_nxt;
    result.pin_level        = relay_nxt ^ cfg.relay_active_low;
    result.alarm_idle       = idle_nxt;
    result.playing_sequence = idle_nxt ? '0 : asp_pkg::SEL_W'(seq_nxt);
  end

endmodule
`default_nettype wire

@@ rtl/core/alarm_sequence_pulser_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "alarm_sequence_pulser_top_defines.svh"
// ----------------------------------------------------------------------------
// alarm_sequence_pulser_top
// alarm relay pulser: conditions pick or release a sequence, ticks play it
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall   asp_pkg::in_item_t
//  out_      output     out_valid / out_stall asp_pkg::out_item_t
//  cfg_      input      cfg_we                cfg_index, cfg_wdata
//
//  one transaction per cycle sustained while the result is not stalled; from
//  input acceptance to result valid: input register, then result register
//  the state update and result come from one pass of compares and one
//  counter increment between the two registers
//  rst_n is synchronous, active low; clears the handshake and the state
//  a stalled result blocks the result register; one more input transaction
//  is held in the input register before in_stall rises
// ----------------------------------------------------------------------------
module alarm_sequence_pulser_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input transactions
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire asp_pkg::in_item_t              in_item,
  // result transactions
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output asp_pkg::out_item_t                  out_item,
  // configuration writes
  input  wire logic                           cfg_we,
  input  wire logic [asp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [asp_pkg::CFG_W-1:0]      cfg_wdata
);

  // input register
  logic                 in_valid_r, in_valid_nxt;
  asp_pkg::in_item_t    in_item_r;
  // result register
  logic                 out_valid_r, out_valid_nxt;
  asp_pkg::out_item_t   out_item_r;

  logic                 advance;
  logic                 in_take;
  asp_pkg::cfg_regs_t   cfg;
  asp_pkg::cond_res_t   cond;
  asp_pkg::out_item_t   result;

  // the held transaction moves on when the result register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  asp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // condition compares on the held transaction
  asp_cond_eval u_cond (
    .item (in_item_r),
    .res  (cond)
  );

  // sequence state steps once per transaction that moves to the result side
  asp_seq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .cond   (cond),
    .sel    (in_item_r.sequence_select),
    .cfg    (cfg),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // stall only while a transaction sits in the input register
  `ASP_ASSERT_SAME(a_stall_has_data, clk, rst_n, in_stall, in_valid_r)
  // a transaction that moves on always shows up as a result
  `ASP_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_r)
  // a blocked transaction is kept, not dropped
  `ASP_ASSERT_NEXT(a_blocked_kept, clk, rst_n, in_valid_r && !advance, in_valid_r)

endmodule
`default_nettype wire

@@ verif/alarm_pulser_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm pulser checker
// watches the channels and config port, predicts each result and compares it
// ----------------------------------------------------------------------------
module alarm_pulser_checker
  import asp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_item_t           in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_item_t          out_item,
  input  logic               cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  output int                 errors,
  output int                 pending,
  output int                 checked
);

  // register copy
  logic [TIME_WIDTH-1:0] on_len  [NUM_SEQUENCES];
  logic [TIME_WIDTH-1:0] off_len [NUM_SEQUENCES];
  logic                  pin_inverted;

  // alarm state
  logic                  alarm_off;
  logic [SEL_W-1:0]      active_seq;
  logic [CNT_W-1:0]      tick_count;
  logic                  relay_energized;

  out_item_t             expected_relay_q [$];
  int                    err_cnt;
  int                    chk_cnt;

  // one transaction through the alarm state, returns the result it produces
  function automatic out_item_t next_relay_result(input in_item_t t);
    logic             hit;
    logic             advance;
    logic [CNT_W-1:0] span;
    out_item_t        r;
    advance = 1'b0;
    case (t.func)
      FUNC_TICK: begin
        if (alarm_off) begin
          relay_energized = 1'b0;
          tick_count      = '0;
        end else if (active_seq == '0 || off_len[active_seq] == '0) begin
          relay_energized = 1'b1;
          tick_count      = '0;
        end else begin
          span = CNT_W'(on_len[active_seq]) + CNT_W'(off_len[active_seq]);
          if (tick_count < CNT_W'(on_len[active_seq])) begin
            relay_energized = 1'b1;
            advance         = 1'b1;
          end else if (tick_count < span) begin
            relay_energized = 1'b0;
            advance         = 1'b1;
          end else begin
            // restart tick, relay holds its level
            tick_count = '0;
          end
        end
        if (advance && tick_count != COUNT_MAX) tick_count = tick_count + 1'b1;
      end
      FUNC_ABOVE, FUNC_BELOW, FUNC_OUTSIDE, FUNC_FLAG: begin
        if (int'(t.sequence_select) < NUM_SEQUENCES) begin
          case (t.func)
            FUNC_ABOVE:   hit = $signed(t.reading) > $signed(t.threshold);
            FUNC_BELOW:   hit = $signed(t.reading) < $signed(t.threshold);
            FUNC_OUTSIDE: hit = ($signed(t.reading) < $signed(t.range_min)) ||
                                ($signed(t.reading) > $signed(t.range_max));
            default:      hit = t.threshold != '0;
          endcase
          if (hit) begin
            active_seq = t.sequence_select;
            alarm_off  = 1'b0;
          end else if (!alarm_off && active_seq == t.sequence_select) begin
            alarm_off = 1'b1;
          end
        end
      end
      default: ;  // unused function codes leave the state alone
    endcase
    r.relay_on         = relay_energized;
    r.pin_level        = relay_energized ^ pin_inverted;
    r.alarm_idle       = alarm_off;
    r.playing_sequence = alarm_off ? '0 : active_seq;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int s = 0; s < NUM_SEQUENCES; s++) begin
        on_len[s]  = '0;
        off_len[s] = '0;
      end
      pin_inverted    = 1'b0;
      alarm_off       = 1'b1;
      active_seq      = '0;
      tick_count      = '0;
      relay_energized = 1'b0;
      expected_relay_q.delete();
      err_cnt = 0;
      chk_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ON_TIME_1:        on_len[1]    = cfg_wdata[TIME_WIDTH-1:0];
          REG_OFF_TIME_1:       off_len[1]   = cfg_wdata[TIME_WIDTH-1:0];
          REG_ON_TIME_2:        on_len[2]    = cfg_wdata[TIME_WIDTH-1:0];
          REG_OFF_TIME_2:       off_len[2]   = cfg_wdata[TIME_WIDTH-1:0];
          REG_ON_TIME_3:        on_len[3]    = cfg_wdata[TIME_WIDTH-1:0];
          REG_OFF_TIME_3:       off_len[3]   = cfg_wdata[TIME_WIDTH-1:0];
          REG_RELAY_ACTIVE_LOW: pin_inverted = cfg_wdata[0];
          default: ;
        endcase
      end
      // results leave before new transactions are queued
      if (out_valid && !out_stall) begin
        if (expected_relay_q.size() == 0) begin
          $display("%0t ns: result with nothing outstanding,", $time,
                   " got relay_on=%0b pin=%0b idle=%0b seq=%0d",
                   out_item.relay_on, out_item.pin_level, out_item.alarm_idle,
                   out_item.playing_sequence);
          err_cnt++;
        end else begin
          want = expected_relay_q.pop_front();
          chk_cnt++;
          if (out_item.relay_on !== want.relay_on || out_item.pin_level !== want.pin_level ||
              out_item.alarm_idle !== want.alarm_idle ||
              out_item.playing_sequence !== want.playing_sequence) begin
            $display("%0t ns: mismatch, expected relay_on=%0b pin=%0b idle=%0b seq=%0d,",
                     $time, want.relay_on, want.pin_level, want.alarm_idle,
                     want.playing_sequence,
                     " got relay_on=%0b pin=%0b idle=%0b seq=%0d",
                     out_item.relay_on, out_item.pin_level,
                     out_item.alarm_idle, out_item.playing_sequence);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) expected_relay_q.push_back(next_relay_result(in_item));
    end
    errors  <= err_cnt;
    pending <= expected_relay_q.size();
    checked <= chk_cnt;
  end

endmodule

@@ verif/tb_alarm_sequence_pulser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm sequence pulser testbench
// directed and random condition and tick transactions over several register
// settings, with random idling on both channels; a checker predicts results
// ----------------------------------------------------------------------------
module tb_alarm_sequence_pulser_top;
  import asp_pkg::*;

  // function codes the block must ignore, and a register index it must ignore
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED_LO = FUNC_FLAG + 1'b1;
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED_HI = {FUNC_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = {CFG_IDX_W{1'b1}};

  localparam int IDLE_PCT      = 21;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 182;
  localparam int CALM_PHASE    = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // no idling on either side while calm is set
  logic calm = 1'b0;

  int errors;
  int pending;
  int checked;
  int sent_cnt = 0;
  int setting_cnt = 0;

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  alarm_sequence_pulser_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alarm_pulser_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_item_t cmd(input logic [FUNC_W-1:0] f, input logic signed [15:0] rd,
                                   input logic signed [15:0] th, input logic signed [15:0] lo,
                                   input logic signed [15:0] hi, input logic [SEL_W-1:0] sel);
    in_item_t t;
    t.func            = f;
    t.reading         = rd;
    t.threshold       = th;
    t.range_min       = lo;
    t.range_max       = hi;
    t.sequence_select = sel;
    return t;
  endfunction

  // mostly ticks and conditions aimed at the favored sequence, some noise
  function automatic in_item_t random_item(input logic [SEL_W-1:0] fav_sel);
    in_item_t           t;
    logic [95:0]        raw;
    logic               want;
    logic signed [15:0] swap;
    int unsigned        pick;
    raw  = {$urandom, $urandom, $urandom};
    t    = raw[$bits(in_item_t)-1:0];
    pick = $urandom_range(0, 99);
    want = 1'($urandom_range(0, 1));
    if (pick < 55) begin
      t.func = FUNC_TICK;
    end else if (pick < 95) begin
      t.func = FUNC_W'($urandom_range(FUNC_ABOVE, FUNC_FLAG));
      if ($urandom_range(0, 99) < 70) t.sequence_select = fav_sel;
      case (t.func)
        FUNC_ABOVE, FUNC_BELOW: begin
          // steer the compare toward the wanted outcome, equal now and then
          if ($urandom_range(0, 19) == 0) begin
            t.threshold = t.reading;
          end else if ((($signed(t.reading) > $signed(t.threshold)) == (t.func == FUNC_ABOVE))
                       != want) begin
            swap        = t.reading;
            t.reading   = t.threshold;
            t.threshold = swap;
          end
        end
        FUNC_OUTSIDE: begin
          if (!want) begin
            if ($signed(t.range_min) > $signed(t.reading)) t.range_min = t.reading;
            if ($signed(t.range_max) < $signed(t.reading)) t.range_max = t.reading;
          end
        end
        default: begin
          if (!want) t.threshold = '0;
        end
      endcase
    end else begin
      t.func = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
    end
    return t;
  endfunction

  // one input transaction, with a random gap in front of it
  task automatic send_item(input in_item_t t);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // wait until every expected result has come back, plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_setting(input logic [TIME_WIDTH-1:0] on1, input logic [TIME_WIDTH-1:0] off1,
                               input logic [TIME_WIDTH-1:0] on2, input logic [TIME_WIDTH-1:0] off2,
                               input logic [TIME_WIDTH-1:0] on3, input logic [TIME_WIDTH-1:0] off3,
                               input logic act_low);
    write_reg(REG_ON_TIME_1, on1);
    write_reg(REG_OFF_TIME_1, off1);
    write_reg(REG_ON_TIME_2, on2);
    write_reg(REG_OFF_TIME_2, off2);
    write_reg(REG_ON_TIME_3, on3);
    write_reg(REG_OFF_TIME_3, off3);
    // upper data bits are junk, only bit 0 counts
    write_reg(REG_RELAY_ACTIVE_LOW, {(CFG_W-1)'($urandom_range(0, 32767)), act_low});
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    setting_cnt++;
  endtask

  function automatic logic [TIME_WIDTH-1:0] short_len();
    return TIME_WIDTH'($urandom_range(0, 12));
  endfunction

  // off time of zero in a fifth of the settings gives a constant-on sequence
  function automatic logic [TIME_WIDTH-1:0] short_off();
    return ($urandom_range(0, 4) == 0) ? '0 : TIME_WIDTH'($urandom_range(1, 12));
  endfunction

  initial begin
    logic [SEL_W-1:0] fav_sel;
    fav_sel = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // seq 1 on 2 off 3, seq 2 on 0 off 2, seq 3 constant on, inverted pin
    write_setting(16'd2, 16'd3, 16'd0, 16'd2, 16'd5, 16'd0, 1'b1);

    // directed transactions
    send_item(cmd(FUNC_TICK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0));        // tick while idle
    send_item(cmd(FUNC_UNUSED_HI, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 2'd1));   // unused code
    send_item(cmd(FUNC_FLAG, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd1));        // flag false, idle
    send_item(cmd(FUNC_ABOVE, 16'sh7FFF, -16'sh8000, 16'sd0, 16'sd0, 2'd1));// extremes, play 1
    // on, on, off, off, off, restart holds off, on again
    repeat (7) send_item(cmd(FUNC_TICK, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 2'd3));
    send_item(cmd(FUNC_BELOW, -16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 2'd2));// switch, count kept
    repeat (3) send_item(cmd(FUNC_TICK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0));
    send_item(cmd(FUNC_ABOVE, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 2'd1));       // false, other seq
    send_item(cmd(FUNC_OUTSIDE, 16'sd0, 16'sd0, -16'sd1, 16'sd1, 2'd2));    // inside, release
    send_item(cmd(FUNC_TICK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0));
    send_item(cmd(FUNC_OUTSIDE, 16'sd2, 16'sd0, -16'sd1, 16'sd1, 2'd3));    // above max
    send_item(cmd(FUNC_TICK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0));
    send_item(cmd(FUNC_FLAG, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 2'd0));       // fixed sequence
    send_item(cmd(FUNC_TICK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0));
    send_item(cmd(FUNC_BELOW, 16'sd7, 16'sd7, 16'sd0, 16'sd0, 2'd0));       // equal, release
    send_item(cmd(FUNC_OUTSIDE, -16'sd3, 16'sd0, -16'sd1, 16'sd1, 2'd0));   // below min
    send_item(cmd(FUNC_TICK, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 2'd0));
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      calm <= (phase == CALM_PHASE);
      case (phase)
        0:       write_setting('0, '0, '0, '0, '0, '0, 1'b0);
        1:       write_setting('1, '1, '0, 16'd1, 16'd1, '1, 1'b0);
        2:       write_setting(16'd1, '1, short_len(), short_off(), '1, 16'd1, 1'b1);
        default: write_setting(short_len(), short_off(), short_len(), short_off(),
                               short_len(), short_off(), 1'($urandom_range(0, 1)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) == 0) fav_sel = SEL_W'($urandom_range(0, NUM_SEQUENCES - 1));
        send_item(random_item(fav_sel));
      end
      drain();
    end

    $display("covered %0d input transactions across %0d register settings,",
             sent_cnt, setting_cnt, " ticks and all conditions");
    $display("%0d results compared, %0d mismatches, %0d left outstanding",
             checked, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ alarm_sequence_pulser_top.f @@
+incdir+rtl/core
rtl/core/asp_pkg.sv
rtl/core/asp_cfg_regs.sv
rtl/core/asp_cond_eval.sv
rtl/core/asp_seq_core.sv
rtl/core/alarm_sequence_pulser_top.sv
verif/alarm_pulser_checker.sv
verif/tb_alarm_sequence_pulser_top.sv
